[src/prl_pkg.sv]
// package for the pid rate loop: config indexes, widths, reset values
// no dependencies
package prl_pkg;
    localparam int unsigned DataW = 32;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned LimW = 31;
    localparam int unsigned AlphaW = 17;

    localparam logic [CfgIdxW-1:0] CfgProp = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgInteg = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgDeriv = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgFf = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgIlim = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgDlim = 3'd5;
    localparam logic [CfgIdxW-1:0] CfgRecip = 3'd6;
    localparam logic [CfgIdxW-1:0] CfgAlpha = 3'd7;

    localparam logic [LimW-1:0] IlimReset = 31'd19661;
    localparam logic [LimW-1:0] DlimReset = 31'd32768000;
    localparam logic [DataW-1:0] RecipReset = 32'd1638;

    // operand width of the serial multiplier: magnitude below 2^35
    localparam int unsigned MagW = 35;
    localparam int unsigned ProdW = MagW + DataW;
    localparam int unsigned CntW = 6;

    typedef struct packed {
        logic start;
        logic neg;
        logic [DataW-1:0] gain;
        logic [MagW-1:0] mag;
    } t_mul_req;

    typedef struct packed {
        logic done;
        logic signed [ProdW:0] res;
    } t_mul_rsp;
endpackage

[src/prl_if.sv]
// valid/ready channel interfaces for the pid rate loop
// depends on prl_pkg
interface prl_in_if import prl_pkg::*; ();
    logic valid;
    logic ready;
    logic signed [DataW-1:0] target;
    logic signed [DataW-1:0] sensed;
    modport source(output valid, target, sensed, input ready);
    modport sink(input valid, target, sensed, output ready);
endinterface

interface prl_out_if import prl_pkg::*; ();
    logic valid;
    logic ready;
    logic signed [DataW-1:0] drive;
    logic saturated;
    modport source(output valid, drive, saturated, input ready);
    modport sink(input valid, drive, saturated, output ready);
endinterface

[src/prl_mul.sv]
// bit-serial shift-add multiplier: floor(gain * signed x / 2^16)
// depends on prl_pkg
module prl_mul import prl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);
    logic [ProdW-1:0] r_acc;
    logic [ProdW:0] n_acc;
    logic [MagW-1:0] r_mag;
    logic [DataW-1:0] r_gain;
    logic r_neg, r_busy, r_done;
    logic [CntW-1:0] r_cnt;
    logic [ProdW-1:0] w_shift;
    logic [ProdW-1:0] w_q;
    logic w_rem;

    // multiplier bits taken lsb first; product shifts into accumulator from top
    always_comb begin
        n_acc = {1'b0, r_acc};
        if (r_mag[0]) begin
            n_acc = {1'b0, r_acc} + {1'b0, r_gain, {MagW{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(MagW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_mag <= i_req.mag;
            r_gain <= i_req.gain;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_acc <= n_acc[ProdW:1];
            r_mag <= {1'b0, r_mag[MagW-1:1]};
        end
    end

    // the add may carry out; keep it by shifting in the carry
    assign w_shift = r_acc;
    assign w_q = w_shift >> 16;
    assign w_rem = |w_shift[15:0];
    assign o_rsp.done = r_done;
    assign o_rsp.res = r_neg ? -$signed({1'b0, w_q}) - (ProdW + 1)'(w_rem)
                             : $signed({1'b0, w_q});
endmodule

[src/pid_rate_loop_iterm_relax.sv]
// top level of the pid rate loop with integral relax
// depends on prl_pkg, prl_if, prl_mul
//  channel | dir | fields
//  in_ch   | in  | target, sensed
//  out_ch  | out | drive, saturated
// one item runs up to seven multiplies (four with relax off) through one shared
// bit-serial multiplier; a new item is accepted only in idle, after the last
// has left its final step. reset is synchronous active low and clears all loop
// state. a result waiting in the output register does not block the next item;
// that item holds in its last step until the register frees.
module pid_rate_loop_iterm_relax import prl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [DataW-1:0]   i_cfg_data,
    prl_in_if.sink             in_ch,
    prl_out_if.source          out_ch
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_REL   = 7'b0000010,
        S_FAC   = 7'b0000100,
        S_IERR  = 7'b0001000,
        S_INT   = 7'b0010000,
        S_TERMS = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    localparam logic signed [MagW:0] Max32 = (MagW+1)'(64'sd2147483647);
    localparam logic signed [MagW:0] Min32 = -(MagW+1)'(64'sd2147483648);

    t_state r_state;
    logic [DataW-1:0] r_kp, r_ki, r_kd, r_kf, r_recip;
    logic [LimW-1:0] r_ilim, r_dlim;
    logic [AlphaW-1:0] r_alpha;
    logic signed [DataW-1:0] r_integral, r_prev_s, r_prev_t, r_smooth;
    logic r_primed, r_was_sat;
    logic signed [DataW-1:0] r_t, r_s, r_err, r_ierr;
    logic signed [DataW+1:0] r_sum;
    logic [1:0] r_term;
    logic r_mbusy;
    logic r_out_v;
    logic signed [DataW-1:0] r_drive;
    logic r_sat;
    t_mul_req w_req;
    t_mul_rsp w_rsp;
    logic signed [MagW:0] w_x;
    logic [DataW-1:0] w_gain;
    logic signed [ProdW:0] w_res;
    logic w_relax;
    logic [AlphaW-1:0] w_a;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [ProdW:0] v);
        if (v > (ProdW+1)'(Max32)) return DataW'(Max32);
        if (v < (ProdW+1)'(Min32)) return DataW'(Min32);
        return v[DataW-1:0];
    endfunction

    assign w_relax = (r_alpha != '0) && (r_ki != '0);
    assign w_a = (r_alpha > AlphaW'(65536)) ? AlphaW'(65536) : r_alpha;
    assign w_res = w_rsp.res;

    // operand select per step
    always_comb begin
        w_x = '0;
        w_gain = '0;
        unique case (r_state)
            S_REL: begin
                w_x = (MagW+1)'(r_t) - (MagW+1)'(r_smooth);
                w_gain = DataW'(w_a);
            end
            S_FAC: begin
                w_x = (MagW+1)'(r_t) - (MagW+1)'(r_smooth);
                if (w_x < 0) w_x = -w_x;
                w_gain = r_recip;
            end
            S_IERR: begin
                w_x = (MagW+1)'(r_err);
                w_gain = r_ierr;
            end
            S_INT: begin
                w_x = (MagW+1)'(r_ierr);
                w_gain = r_ki;
            end
            S_TERMS: begin
                case (r_term)
                    2'd0: begin
                        w_x = (MagW+1)'(r_err);
                        w_gain = r_kp;
                    end
                    2'd1: begin
                        w_x = (MagW+1)'(r_prev_s) - (MagW+1)'(r_s);
                        w_gain = r_kd;
                    end
                    default: begin
                        w_x = (MagW+1)'(r_t) - (MagW+1)'(r_prev_t);
                        w_gain = r_kf;
                    end
                endcase
            end
            default: ;
        endcase
        w_req.neg = w_x < 0;
        w_req.mag = w_x < 0 ? MagW'(-w_x) : MagW'(w_x);
        w_req.gain = w_gain;
        w_req.start = 1'b0;
        if (!r_mbusy && r_state != S_IDLE && r_state != S_OUT) w_req.start = 1'b1;
    end

    prl_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign in_ch.ready = (r_state == S_IDLE);
    assign out_ch.valid = r_out_v;
    assign out_ch.drive = r_drive;
    assign out_ch.saturated = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0; r_ki <= '0; r_kd <= '0; r_kf <= '0;
            r_ilim <= IlimReset; r_dlim <= DlimReset;
            r_recip <= RecipReset; r_alpha <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgProp:  r_kp <= i_cfg_data;
                CfgInteg: r_ki <= i_cfg_data;
                CfgDeriv: r_kd <= i_cfg_data;
                CfgFf:    r_kf <= i_cfg_data;
                CfgIlim:  r_ilim <= i_cfg_data[LimW-1:0];
                CfgDlim:  r_dlim <= i_cfg_data[LimW-1:0];
                CfgRecip: r_recip <= i_cfg_data;
                CfgAlpha: r_alpha <= i_cfg_data[AlphaW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [ProdW:0] acc, f, lim;
        logic signed [DataW+1:0] tot, dl;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mbusy <= 1'b0;
            r_out_v <= 1'b0;
            r_integral <= '0; r_prev_s <= '0; r_prev_t <= '0; r_smooth <= '0;
            r_primed <= 1'b0; r_was_sat <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready && r_state != S_OUT) r_out_v <= 1'b0;
            if (w_req.start) r_mbusy <= 1'b1;
            if (w_rsp.done) r_mbusy <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_t <= in_ch.target;
                        r_s <= in_ch.sensed;
                        r_err <= sat32((ProdW+1)'(in_ch.target) - (ProdW+1)'(in_ch.sensed));
                        r_term <= 2'd0;
                        r_sum <= '0;
                        r_state <= w_relax ? S_REL : S_TERMS;
                    end
                end
                S_REL: if (w_rsp.done) begin
                    r_smooth <= sat32((ProdW+1)'(r_smooth) + w_res);
                    r_state <= S_FAC;
                end
                S_FAC: if (w_rsp.done) begin
                    f = (w_res >= (ProdW+1)'(65536)) ? '0 : (ProdW+1)'(65536) - w_res;
                    r_ierr <= f[DataW-1:0];
                    r_state <= S_IERR;
                end
                S_IERR: if (w_rsp.done) begin
                    if ((r_integral > 0 && r_err > 0) || (r_integral < 0 && r_err < 0))
                        r_ierr <= w_res[DataW-1:0];
                    else
                        r_ierr <= r_err;
                    r_state <= S_INT;
                end
                S_INT: if (w_rsp.done) begin
                    acc = (ProdW+1)'(r_integral) + w_res;
                    lim = (ProdW+1)'(r_ilim);
                    if (acc > lim) acc = lim;
                    if (acc < -lim) acc = -lim;
                    if (!r_was_sat) r_integral <= acc[DataW-1:0];
                    r_state <= S_TERMS;
                end
                S_TERMS: if (w_rsp.done) begin
                    if (r_term == 2'd0) begin
                        r_sum <= (DataW+2)'(sat32(w_res));
                        if (!w_relax) begin
                            if (r_ki == '0) r_integral <= '0;
                            r_ierr <= r_err;
                            r_state <= S_INT;
                            r_term <= 2'd1;
                        end else r_term <= 2'd1;
                    end else begin
                        if ((r_term == 2'd1 ? r_kd != '0 : r_kf != '0) && r_primed)
                            r_sum <= r_sum + (DataW+2)'(sat32(w_res));
                        if (r_term == 2'd2) r_state <= S_OUT;
                        r_term <= r_term + 1'b1;
                    end
                end
                S_OUT: if (!r_out_v || out_ch.ready) begin
                    tot = r_sum + (DataW+2)'(r_integral);
                    dl = (DataW+2)'(r_dlim);
                    r_was_sat <= (tot < 0 ? -tot : tot) >= dl;
                    r_sat <= (tot < 0 ? -tot : tot) >= dl;
                    if (tot > dl) tot = dl;
                    if (tot < -dl) tot = -dl;
                    r_drive <= tot[DataW-1:0];
                    r_prev_s <= r_s;
                    r_prev_t <= r_t;
                    r_primed <= 1'b1;
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[sim/tb_pid_rate_loop_iterm_relax.sv]
// testbench for pid_rate_loop_iterm_relax: directed table then random items,
// checked against a predictor of the q16.16 pid loop with integral relax
// depends on prl_pkg, prl_if and the rtl of the block
`timescale 1ns / 1ps

module tb_pid_rate_loop_iterm_relax;
    import prl_pkg::*;

    typedef struct packed {
        logic signed [31:0] drive;
        logic saturated;
    } t_drive;

    typedef struct {
        logic [31:0] target;
        logic [31:0] sensed;
        logic        has_exp;
        logic [31:0] exp_drive;
        logic        exp_sat;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [DataW-1:0] i_cfg_data = '0;

    prl_in_if in_ch ();
    prl_out_if out_ch ();

    pid_rate_loop_iterm_relax dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    // predictor copy of configuration and loop state
    logic [31:0] kp, ki, kd, kf, rrecip;
    logic [30:0] ilim, dlim;
    logic [16:0] ralpha;
    longint integ, psens, ptarg, rsmooth;
    bit primed, was_sat;

    t_drive drive_queue[$];
    t_row   rows[$];
    int     errors = 0;
    int     sent = 0;
    int     got = 0;
    bit     rx_stall_on = 1'b1;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor(gain * x / 2^16), x within 2^34
    function automatic longint gain_mul(logic [31:0] gain, longint x);
        logic [99:0] prod;
        logic [63:0] mag;
        longint q;
        mag = (x < 0) ? -x : x;
        prod = {68'd0, gain} * {36'd0, mag};
        q = longint'(prod[79:16]);
        if (x < 0) return -q - ((prod[15:0] != 0) ? 1 : 0);
        return q;
    endfunction

    function automatic void reset_predictor();
        kp = '0; ki = '0; kd = '0; kf = '0;
        ilim = IlimReset; dlim = DlimReset; rrecip = RecipReset; ralpha = '0;
        integ = 0; psens = 0; ptarg = 0; rsmooth = 0;
        primed = 0; was_sat = 0;
    endfunction

    function automatic t_drive pid_tick(logic [31:0] tgt, logic [31:0] sns);
        longint t, s, err, pterm, ierr, dterm, fterm, sum, lim, acc, chg, q;
        longint a, factor;
        t_drive r;
        t = longint'(signed'(tgt));
        s = longint'(signed'(sns));
        err = sat32(t - s);
        pterm = sat32(gain_mul(kp, err));
        ierr = err;
        dterm = 0;
        fterm = 0;
        if (ralpha != 0 && ki != 0) begin
            a = (ralpha > 17'd65536) ? 65536 : longint'(ralpha);
            rsmooth = sat32(rsmooth + gain_mul(a[31:0], t - rsmooth));
            chg = t - rsmooth;
            if (chg < 0) chg = -chg;
            q = gain_mul(rrecip, chg);
            factor = (q >= 65536) ? 0 : 65536 - q;
            if ((integ > 0 && err > 0) || (integ < 0 && err < 0))
                ierr = gain_mul(factor[31:0], err);
        end
        if (ki != 0) begin
            if (!was_sat) begin
                acc = integ + gain_mul(ki, ierr);
                if (acc > longint'(ilim)) acc = longint'(ilim);
                if (acc < -longint'(ilim)) acc = -longint'(ilim);
                integ = acc;
            end
        end else begin
            integ = 0;
        end
        if (kd != 0 && primed) dterm = sat32(gain_mul(kd, psens - s));
        if (kf != 0 && primed) fterm = sat32(gain_mul(kf, t - ptarg));
        psens = s;
        ptarg = t;
        primed = 1;
        sum = pterm + integ + dterm + fterm;
        lim = longint'(dlim);
        was_sat = ((sum < 0) ? -sum : sum) >= lim;
        if (sum > lim) sum = lim;
        if (sum < -lim) sum = -lim;
        r.drive = sum[31:0];
        r.saturated = was_sat;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] seen, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, seen, want, $time);
        errors++;
    endtask

    task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CfgProp: kp = val;
            CfgInteg: ki = val;
            CfgDeriv: kd = val;
            CfgFf: kf = val;
            CfgIlim: ilim = val[30:0];
            CfgDlim: dlim = val[30:0];
            CfgRecip: rrecip = val;
            CfgAlpha: ralpha = val[16:0];
            default: ;
        endcase
    endtask

    task automatic send_item(logic [31:0] tgt, logic [31:0] sns, bit has_exp,
                             logic [31:0] ed, logic es);
        t_drive p;
        p = pid_tick(tgt, sns);
        if (has_exp && (p.drive != ed || p.saturated != es))
            report("directed row", {p.drive[30:0], p.saturated}, {ed[30:0], es});
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.target <= tgt;
        in_ch.sensed <= sns;
        do @(posedge i_clk); while (!in_ch.ready);
        drive_queue.push_back(p);
        sent++;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        int n;
        n = 0;
        while (drive_queue.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_val(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
            2: return 32'($signed($urandom_range(0, 24'hFFFFFF)) - 32'sh800000);
            default: return ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
        endcase
    endfunction

    // output side with its own stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (drive_queue.size() == 0) begin
                report("unexpected item", out_ch.drive, 32'hx);
            end else begin
                if (out_ch.drive !== drive_queue[0].drive)
                    report("drive", out_ch.drive, drive_queue[0].drive);
                if (out_ch.saturated !== drive_queue[0].saturated)
                    report("saturated", {31'd0, out_ch.saturated},
                           {31'd0, drive_queue[0].saturated});
                void'(drive_queue.pop_front());
            end
            got++;
        end
    end

    always @(negedge i_clk) begin
        if (rx_stall_on) out_ch.ready <= ($urandom_range(0, 3) != 0);
        else out_ch.ready <= 1'b1;
    end

    initial begin
        int burst;
        in_ch.valid = 1'b0;
        in_ch.target = '0;
        in_ch.sensed = '0;
        out_ch.ready = 1'b0;
        reset_predictor();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows, reset configuration then extremes
        rows.push_back('{32'h0, 32'h0, 1, 32'h0, 1'b0});
        rows.push_back('{32'h7FFFFFFF, 32'h80000000, 1, 32'h0, 1'b0});
        rows.push_back('{32'h80000000, 32'h7FFFFFFF, 0, 0, 0});
        rows.push_back('{32'h00010000, 32'h00008000, 0, 0, 0});
        foreach (rows[k]) send_item(rows[k].target, rows[k].sensed,
                                    rows[k].has_exp, rows[k].exp_drive, rows[k].exp_sat);
        drain();
        cfg_write(CfgProp, 32'hFFFFFFFF);
        cfg_write(CfgDeriv, 32'hFFFFFFFF);
        cfg_write(CfgFf, 32'hFFFFFFFF);
        cfg_write(CfgIlim, 32'h7FFFFFFF);
        cfg_write(CfgDlim, 32'h7FFFFFFF);
        send_item(32'h7FFFFFFF, 32'h80000000, 1, 32'h7FFFFFFF, 1'b1);
        send_item(32'h80000000, 32'h7FFFFFFF, 1, 32'h80000001, 1'b1);
        send_item(32'h12345678, 32'h00000000, 0, 0, 0);
        drain();
        // zero drive limit, alpha above one, zero cutoff reciprocal
        cfg_write(CfgDlim, 32'h0);
        cfg_write(CfgInteg, 32'h00010000);
        cfg_write(CfgAlpha, 32'h1FFFF);
        send_item(32'h00050000, 32'h00010000, 1, 32'h0, 1'b1);
        send_item(32'hFFFF0000, 32'h00010000, 1, 32'h0, 1'b1);
        drain();
        cfg_write(CfgDlim, 32'h01000000);
        cfg_write(CfgRecip, 32'h0);
        cfg_write(CfgProp, 32'h00010000);
        for (int k = 0; k < 6; k++) send_item(32'h00030000 * k, 32'h0, 0, 0, 0);
        drain();
        cfg_write(CfgInteg, 32'h0);
        send_item(32'h00020000, 32'h0, 0, 0, 0);
        send_item(32'h00020000, 32'h0, 0, 0, 0);
        drain();

        // random phases, each with fresh settings
        for (int ph = 0; ph < 12; ph++) begin
            int mode;
            rx_stall_on = (ph % 3 != 2);
            cfg_write(CfgProp, (ph == 0) ? 32'hFFFFFFFF : $urandom_range(0, 32'h00040000));
            cfg_write(CfgInteg, (ph % 4 == 3) ? 32'h0 :
                      ((ph == 1) ? 32'hFFFFFFFF : $urandom_range(0, 32'h00020000)));
            cfg_write(CfgDeriv, (ph % 5 == 4) ? 32'h0 : $urandom());
            cfg_write(CfgFf, (ph % 5 == 2) ? 32'h0 : $urandom() >> $urandom_range(0, 20));
            cfg_write(CfgIlim, (ph == 5) ? 32'h0 : $urandom() >> $urandom_range(1, 16));
            cfg_write(CfgDlim, (ph == 6) ? 32'h0 :
                      ((ph == 7) ? 32'h7FFFFFFF : $urandom() >> $urandom_range(1, 12)));
            cfg_write(CfgRecip, (ph == 8) ? 32'h0 :
                      ((ph == 9) ? 32'hFFFFFFFF : $urandom_range(0, 32'h00030000)));
            cfg_write(CfgAlpha, (ph % 4 == 1) ? 32'h0 :
                      ((ph == 10) ? 32'h1FFFF : $urandom_range(0, 32'h1FFFF)));
            mode = ph % 4;
            for (int k = 0; k < 50; ) begin
                burst = $urandom_range(1, 8);
                for (int b = 0; b < burst && k < 50; b++, k++)
                    send_item(rnd_val(mode), rnd_val($urandom_range(0, 3)), 0, 0, 0);
                repeat ($urandom_range(0, 30)) @(negedge i_clk);
            end
            drain();
        end

        if (errors == 0 && drive_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[pid_rate_loop_iterm_relax.f]
src/prl_pkg.sv
src/prl_if.sv
src/prl_mul.sv
src/pid_rate_loop_iterm_relax.sv
sim/tb_pid_rate_loop_iterm_relax.sv
